FILE: rtl/ccrl_pkg.sv
// ccrl_pkg: types and constants for the cc change rate limiter
// no dependencies
`default_nettype none

package ccrl_pkg;

    localparam int unsigned NUM_ENTRIES = 8;
    localparam int unsigned LEVEL_W     = 15;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 15'd16384;

    localparam logic [15:0] MIN_GAP_RESET   = 16'd10;
    localparam logic [14:0] THRESHOLD_RESET = 15'd164;
    localparam logic [6:0]  V0_BASE_RESET   = 7'd71;
    localparam logic [6:0]  V1_BASE_RESET   = 7'd75;

    localparam logic [6:0]  CC_SCALE = 7'd127;
    localparam logic [1:0]  CODE_TOP = 2'd3;

    typedef enum logic [1:0] {
        REG_MIN_GAP    = 2'd0,
        REG_THRESHOLD  = 2'd1,
        REG_V0_BASE    = 2'd2,
        REG_V1_BASE    = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: rtl/cc_change_rate_limiter.sv
// cc_change_rate_limiter: dead-band rate limiter for control-change sends
// depends on ccrl_pkg
//
//  channel   ports                                      handshake
//  -------   -----------------------------------------  ---------------------------
//  item in   voice parameter_req level now_ms           start && !busy
//  item out  send_now cc_number cc_value                done, one cycle, no stall
//  config    wr_en wr_index wr_data                     wr_en
//
// an item reads its entry at acceptance, is checked and written back in the next
// cycle (busy high), and its result shows on done in the cycle after that
// a new item is taken only while busy is low, so it waits for the write back of the last
// reset clears the valid bits of all eight entries at once, no clearing pass
// the receiver cannot stall; every accepted item gives exactly one result
`default_nettype none

module cc_change_rate_limiter
    import ccrl_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic        voice,
    input  wire logic [2:0]  parameter_req,
    input  wire logic [15:0] level,
    input  wire logic [31:0] now_ms,
    output      logic        done,
    output      logic        send_now,
    output      logic [6:0]  cc_number,
    output      logic [6:0]  cc_value,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data
);

    localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);

    // configuration
    logic [15:0] min_gap_reg;
    logic [14:0] threshold_reg;
    logic [6:0]  v0_base_reg;
    logic [6:0]  v1_base_reg;

    // entry state memories
    logic [LEVEL_W-1:0]    level_mem [NUM_ENTRIES];
    logic [TIME_WIDTH-1:0] time_mem  [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] vld_reg;

    // stage registers
    logic                  busy_reg;
    logic                  code_ok_reg;
    logic                  voice_reg;
    logic [1:0]            code_reg;
    logic [LEVEL_W-1:0]    clamped_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [LEVEL_W-1:0]    rd_level_reg;
    logic [TIME_WIDTH-1:0] rd_time_reg;
    logic                  rd_vld_reg;

    // output registers
    logic       done_reg;
    logic       send_reg;
    logic [6:0] cc_number_reg;
    logic [6:0] cc_value_reg;

    logic                  accept;
    logic [IDX_W-1:0]      in_idx;
    logic [LEVEL_W-1:0]    in_clamped;
    logic [TIME_WIDTH+31:0] now_ext;
    logic [TIME_WIDTH-1:0] in_now;

    logic [IDX_W-1:0]      st_idx;
    logic [LEVEL_W-1:0]    old_level;
    logic [TIME_WIDTH-1:0] old_time;
    logic [TIME_WIDTH-1:0] gap;
    logic                  gap_ok;
    logic [LEVEL_W-1:0]    diff;
    logic                  diff_ok;
    logic                  send;
    logic [6:0]            base;
    logic [6:0]            cc_number_next;
    logic [LEVEL_W+6:0]    scaled;
    logic [6:0]            cc_value_next;

    assign accept  = start && !busy_reg;
    assign in_idx  = {voice, parameter_req[1:0]};
    assign now_ext = {{TIME_WIDTH{1'b0}}, now_ms};
    assign in_now  = now_ext[TIME_WIDTH-1:0];

    always_comb
    begin
        if (level[15])
        begin
            in_clamped = '0;
        end
        else if (level[14:0] > LEVEL_FULL)
        begin
            in_clamped = LEVEL_FULL;
        end
        else
        begin
            in_clamped = level[14:0];
        end
    end

    assign st_idx    = {voice_reg, code_reg};
    assign old_level = rd_vld_reg ? rd_level_reg : '0;
    assign old_time  = rd_vld_reg ? rd_time_reg : '0;
    assign gap       = now_reg - old_time;
    assign gap_ok    = {16'd0, gap} >= {{TIME_WIDTH{1'b0}}, min_gap_reg};
    assign diff      = (clamped_reg >= old_level) ? (clamped_reg - old_level)
                                                  : (old_level - clamped_reg);
    assign diff_ok   = diff >= threshold_reg;
    assign send      = busy_reg && code_ok_reg && gap_ok && diff_ok;

    assign base           = voice_reg ? v1_base_reg : v0_base_reg;
    assign cc_number_next = base + {5'd0, CODE_TOP} - {5'd0, code_reg};
    assign scaled         = {7'd0, clamped_reg} * {{LEVEL_W{1'b0}}, CC_SCALE};
    assign cc_value_next  = scaled[LEVEL_W+5:LEVEL_W-1];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg   <= MIN_GAP_RESET;
            threshold_reg <= THRESHOLD_RESET;
            v0_base_reg   <= V0_BASE_RESET;
            v1_base_reg   <= V1_BASE_RESET;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_MIN_GAP:   min_gap_reg   <= wr_data;
                REG_THRESHOLD: threshold_reg <= wr_data[14:0];
                REG_V0_BASE:   v0_base_reg   <= wr_data[6:0];
                REG_V1_BASE:   v1_base_reg   <= wr_data[6:0];
                default: ;
            endcase
        end
    end

    // control and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            vld_reg       <= '0;
            done_reg      <= 1'b0;
            send_reg      <= 1'b0;
            cc_number_reg <= '0;
            cc_value_reg  <= '0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            send_reg <= send;
            if (send)
            begin
                vld_reg[st_idx] <= 1'b1;
                cc_number_reg   <= cc_number_next;
                cc_value_reg    <= cc_value_next;
            end
            else
            begin
                cc_number_reg <= '0;
                cc_value_reg  <= '0;
            end
        end
    end

    // item capture and entry read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_ok_reg  <= !parameter_req[2];
            voice_reg    <= voice;
            code_reg     <= parameter_req[1:0];
            clamped_reg  <= in_clamped;
            now_reg      <= in_now;
            rd_level_reg <= level_mem[in_idx];
            rd_time_reg  <= time_mem[in_idx];
            rd_vld_reg   <= vld_reg[in_idx];
        end
    end

    // entry write back
    always_ff @(posedge clk)
    begin
        if (send)
        begin
            level_mem[st_idx] <= clamped_reg;
            time_mem[st_idx]  <= now_reg;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign send_now  = send_reg;
    assign cc_number = cc_number_reg;
    assign cc_value  = cc_value_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding busy cycle");

    a_send_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        send_now |-> done)
        else $error("send outside a result cycle");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");
`endif

endmodule

`default_nettype wire

FILE: verif/ccrl_checker.sv
`timescale 1ns / 100ps
// ccrl_checker: watches the item, result and register ports of cc_change_rate_limiter,
// predicts every result and compares it field by field; depends on ccrl_pkg

module ccrl_checker
    import ccrl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        voice,
    input  wire logic [2:0]  parameter_req,
    input  wire logic [15:0] level,
    input  wire logic [31:0] now_ms,
    input  wire logic        done,
    input  wire logic        send_now,
    input  wire logic [6:0]  cc_number,
    input  wire logic [6:0]  cc_value,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data,
    output int unsigned      fail_count,
    output int unsigned      pending
);

    typedef struct packed {
        logic       send;
        logic [6:0] number;
        logic [6:0] value;
    } cc_result_t;

    cc_result_t         cc_expected_q[$];
    logic [15:0]        gap_limit;
    logic [14:0]        change_min;
    logic [6:0]         base_v0;
    logic [6:0]         base_v1;
    logic [LEVEL_W-1:0] sent_level [NUM_ENTRIES];
    logic [31:0]        sent_ms [NUM_ENTRIES];

    task automatic log_cc_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("%0t ccrl_checker: %s got %0d want %0d", $time, what, got, want);
    endtask

    // works out the result of one item and updates the entry it sends from
    function automatic cc_result_t predict_cc_send(input logic v, input logic [2:0] code,
                                                   input logic [15:0] raw,
                                                   input logic [31:0] now);
        cc_result_t         res;
        logic [LEVEL_W-1:0] clamped;
        logic [2:0]         idx;
        logic [31:0]        gap;
        logic [LEVEL_W-1:0] diff;
        logic [21:0]        prod;
        res = '0;
        if (code > {1'b0, CODE_TOP})
            return res;
        if (raw[15])
            clamped = '0;
        else if (raw[14:0] > LEVEL_FULL)
            clamped = LEVEL_FULL;
        else
            clamped = raw[14:0];
        idx = {v, code[1:0]};
        gap = now - sent_ms[idx];
        if (gap < {16'd0, gap_limit})
            return res;
        diff = (clamped >= sent_level[idx]) ? clamped - sent_level[idx]
                                            : sent_level[idx] - clamped;
        if (diff < change_min)
            return res;
        prod = 22'(clamped) * 22'd127;
        res.send = 1'b1;
        res.number = (v ? base_v1 : base_v0) + 7'd3 - 7'(code[1:0]);
        res.value = prod[20:14];
        sent_level[idx] = clamped;
        sent_ms[idx] = now;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cc_result_t want;
        if (!rst_n)
        begin
            cc_expected_q.delete();
            pending = 0;
            fail_count = 0;
            gap_limit = MIN_GAP_RESET;
            change_min = THRESHOLD_RESET;
            base_v0 = V0_BASE_RESET;
            base_v1 = V1_BASE_RESET;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                sent_level[i] = '0;
                sent_ms[i] = '0;
            end
        end
        else
        begin
            if (done)
            begin
                if (cc_expected_q.size() == 0)
                    log_cc_mismatch("unexpected result, send_now", send_now, 0);
                else
                begin
                    want = cc_expected_q.pop_front();
                    if (send_now !== want.send)
                        log_cc_mismatch("send_now", send_now, want.send);
                    if (cc_number !== want.number)
                        log_cc_mismatch("cc_number", cc_number, want.number);
                    if (cc_value !== want.value)
                        log_cc_mismatch("cc_value", cc_value, want.value);
                end
            end
            if (start && !busy)
                cc_expected_q.push_back(predict_cc_send(voice, parameter_req, level, now_ms));
            if (wr_en)
            begin
                case (cfg_index_t'(wr_index))
                    REG_MIN_GAP:   gap_limit = wr_data;
                    REG_THRESHOLD: change_min = wr_data[14:0];
                    REG_V0_BASE:   base_v0 = wr_data[6:0];
                    REG_V1_BASE:   base_v1 = wr_data[6:0];
                    default:       ;
                endcase
            end
            pending = cc_expected_q.size();
        end
    end

endmodule

FILE: verif/tb_cc_change_rate_limiter.sv
`timescale 1ns / 100ps
// tb_cc_change_rate_limiter: drives items and register writes into cc_change_rate_limiter
// and gives the verdict; depends on ccrl_pkg, cc_change_rate_limiter and ccrl_checker

module tb_cc_change_rate_limiter;
    import ccrl_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        voice = 1'b0;
    logic [2:0]  parameter_req = '0;
    logic [15:0] level = '0;
    logic [31:0] now_ms = '0;
    logic        done;
    logic        send_now;
    logic [6:0]  cc_number;
    logic [6:0]  cc_value;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = REG_MIN_GAP;
    logic [15:0] wr_data = '0;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned stall_cycles = 0;
    logic [31:0] ms_clock = '0;

    cc_change_rate_limiter i_dut (.*);

    ccrl_checker i_checker (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_cc_change_rate_limiter: errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic hold_off(input int unsigned pct);
        int unsigned gap_cycles;
        gap_cycles = 0;
        while ($urandom_range(0, 99) < pct)
            gap_cycles++;
        if (gap_cycles > 0)
        begin
            start <= 1'b0;
            repeat (gap_cycles) @(negedge clk);
        end
    endtask

    task automatic issue_item(input int unsigned pct, input logic v, input logic [2:0] code,
                              input logic [15:0] lvl, input logic [31:0] t);
        hold_off(pct);
        voice <= v;
        parameter_req <= code;
        level <= lvl;
        now_ms <= t;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_limits(input logic [15:0] gap, input logic [15:0] thr,
                                  input logic [15:0] b0, input logic [15:0] b1);
        wr_en <= 1'b1;
        wr_index <= REG_MIN_GAP;
        wr_data <= gap;
        @(negedge clk);
        wr_index <= REG_THRESHOLD;
        wr_data <= thr;
        @(negedge clk);
        wr_index <= REG_V0_BASE;
        wr_data <= b0;
        @(negedge clk);
        wr_index <= REG_V1_BASE;
        wr_data <= b1;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count, input int unsigned pct,
                              input int unsigned gap);
        int unsigned burst_pct;
        int unsigned pick;
        logic [2:0]  code;
        logic [15:0] lvl;
        burst_pct = pct;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 16 == 0)
                burst_pct = ($urandom_range(0, 3) == 0) ? 0 : pct;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                ms_clock = $urandom();
            else if (pick < 25)
                ms_clock += gap;
            else if (pick < 35)
                ms_clock += $urandom_range(0, 3);
            else
                ms_clock += $urandom_range(0, 2 * gap + 8);
            if ($urandom_range(0, 99) < 85)
                code = 3'($urandom_range(0, 3));
            else
                code = 3'($urandom_range(4, 7));
            case ($urandom_range(0, 9))
                0:       lvl = 16'd0;
                1:       lvl = 16'd16384;
                2:       lvl = 16'($urandom_range(32768, 65535));
                3:       lvl = 16'($urandom_range(16385, 32767));
                default: lvl = 16'($urandom_range(0, 16384));
            endcase
            issue_item(burst_pct, 1'($urandom_range(0, 1)), code, lvl, ms_clock);
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        program_limits(16'd10, 16'd164, 16'd71, 16'd75);

        issue_item(18, 1'b0, 3'd0, 16'd16384, 32'd10);
        issue_item(18, 1'b0, 3'd0, 16'd16384, 32'd20);
        issue_item(18, 1'b0, 3'd0, 16'h8000, 32'd30);
        issue_item(18, 1'b0, 3'd0, 16'd164, 32'd39);
        issue_item(18, 1'b0, 3'd0, 16'd164, 32'd40);
        issue_item(18, 1'b0, 3'd0, 16'h7FFF, 32'd50);
        // change one below threshold
        issue_item(18, 1'b0, 3'd0, 16'd16221, 32'd70);
        issue_item(18, 1'b0, 3'd1, 16'd16385, 32'd100);
        issue_item(18, 1'b0, 3'd2, 16'd8192, 32'd100);
        issue_item(18, 1'b0, 3'd3, 16'd16383, 32'd100);
        // time wraps past the top
        issue_item(18, 1'b1, 3'd0, 16'd200, 32'hFFFF_FFFF);
        issue_item(18, 1'b1, 3'd0, 16'd0, 32'd8);
        issue_item(18, 1'b1, 3'd0, 16'd0, 32'd9);
        issue_item(18, 1'b1, 3'd3, 16'd16384, 32'd0);
        issue_item(18, 1'b1, 3'd3, 16'd16384, 32'd10);
        issue_item(18, 1'b0, 3'd4, 16'd16384, 32'd1000);
        issue_item(18, 1'b1, 3'd7, 16'd16384, 32'd1000);

        // bases that wrap and give cc number zero
        wait_idle();
        program_limits(16'd0, 16'd0, 16'd125, 16'd127);
        for (int i = 0; i < 8; i++)
            issue_item(18, 1'(i / 4), 3'(i % 4), 16'($urandom_range(0, 16384)), 32'd2000);

        wait_idle();
        program_limits(16'd0, 16'd0, 16'd0, 16'd124);
        run_random(110, 18, 0);
        wait_idle();
        program_limits(16'd20, 16'd1000, 16'd100, 16'd31);
        run_random(110, 18, 20);
        wait_idle();
        program_limits(16'hFFFF, 16'd16384, 16'd3, 16'd64);
        run_random(100, 86, 65535);
        wait_idle();
        // threshold above full scale
        program_limits(16'd5, 16'hFFFF, 16'd127, 16'd1);
        run_random(40, 86, 5);
        wait_idle();
        program_limits(16'd10, 16'd164, 16'd71, 16'd75);
        run_random(150, 0, 10);
        wait_idle();

        if (fail_count == 0)
            $display("tb_cc_change_rate_limiter: clean");
        else
            $display("tb_cc_change_rate_limiter: errors");
        $finish;
    end

endmodule
